### rtl/skt_pkg.sv
// shared types and constants for the sorted key table
package skt_pkg;

   localparam int KEY_WIDTH             = 32;
   localparam int PAYLOAD_IN_WIDTH      = 32;
   localparam int PAYLOAD_OUT_WIDTH     = 32;
   localparam int STATUS_WIDTH          = 3;
   localparam int POSITION_WIDTH        = 7;
   localparam int TABLE_DEPTH_DEFAULT   = 64;
   localparam int PAYLOAD_WIDTH_DEFAULT = 32;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_FIND   = 1'b1
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_INSERTED  = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_FOUND     = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic compare_en;
      logic insert_en;
   } cell_ctrl_type;

   typedef struct packed {
      logic hit;
      logic full;
   } chain_status_type;

endpackage

### rtl/skt_cell.sv
// one table entry: stored key and payload, compare against the search key, shift on insert
module skt_cell #(
   parameter int PAYLOAD_WIDTH = skt_pkg::PAYLOAD_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  skt_pkg::cell_ctrl_type          ctrl,
   input  logic [skt_pkg::KEY_WIDTH-1:0]   cmp_key,
   input  logic [skt_pkg::KEY_WIDTH-1:0]   new_key,
   input  logic [PAYLOAD_WIDTH-1:0]        new_payload,
   input  logic [skt_pkg::KEY_WIDTH-1:0]   left_key,
   input  logic [PAYLOAD_WIDTH-1:0]        left_payload,
   input  logic                            left_valid,
   input  logic                            left_lt,
   output logic [skt_pkg::KEY_WIDTH-1:0]   key,
   output logic [PAYLOAD_WIDTH-1:0]        payload,
   output logic                            valid,
   output logic                            lt,
   output logic                            eq
);

   logic [skt_pkg::KEY_WIDTH-1:0] key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0]      payload_ff, payload_in;
   logic                          valid_ff, valid_in;
   logic                          lt_ff, eq_ff;
   logic                          take;

   // entries at or past the insertion point move up by one
   assign take = ctrl.insert_en && !lt_ff;

   always_comb begin
      if (left_lt) begin
         key_in     = new_key;
         payload_in = new_payload;
         valid_in   = 1'b1;
      end else begin
         key_in     = left_key;
         payload_in = left_payload;
         valid_in   = left_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         lt_ff    <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         if (ctrl.compare_en) begin
            lt_ff <= valid_ff && (key_ff < cmp_key);
            eq_ff <= valid_ff && (key_ff == cmp_key);
         end
         if (take) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         key_ff     <= key_in;
         payload_ff <= payload_in;
      end
   end

   assign key     = key_ff;
   assign payload = payload_ff;
   assign valid   = valid_ff;
   assign lt      = lt_ff;
   assign eq      = eq_ff;

endmodule

### rtl/skt_chain.sv
// row of entry cells with the position encoder and found-payload select
module skt_chain #(
   parameter int TABLE_DEPTH   = skt_pkg::TABLE_DEPTH_DEFAULT,
   parameter int PAYLOAD_WIDTH = skt_pkg::PAYLOAD_WIDTH_DEFAULT,
   localparam int POS_W        = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  skt_pkg::cell_ctrl_type          ctrl,
   input  logic [skt_pkg::KEY_WIDTH-1:0]   cmp_key,
   input  logic [PAYLOAD_WIDTH-1:0]        new_payload,
   output skt_pkg::chain_status_type       status,
   output logic [POS_W-1:0]                position,
   output logic [PAYLOAD_WIDTH-1:0]        found_payload
);

   logic [skt_pkg::KEY_WIDTH-1:0] cell_key     [TABLE_DEPTH];
   logic [PAYLOAD_WIDTH-1:0]      cell_payload [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]        valid_vec;
   logic [TABLE_DEPTH-1:0]        lt_vec;
   logic [TABLE_DEPTH-1:0]        eq_vec;
   logic [TABLE_DEPTH:0]          boundary;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         skt_cell #(.PAYLOAD_WIDTH(PAYLOAD_WIDTH)) u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (ctrl),
            .cmp_key      (cmp_key),
            .new_key      (cmp_key),
            .new_payload  (new_payload),
            .left_key     (cmp_key),
            .left_payload (new_payload),
            .left_valid   (1'b1),
            .left_lt      (1'b1),
            .key          (cell_key[i]),
            .payload      (cell_payload[i]),
            .valid        (valid_vec[i]),
            .lt           (lt_vec[i]),
            .eq           (eq_vec[i])
         );
      end else begin : g_body
         skt_cell #(.PAYLOAD_WIDTH(PAYLOAD_WIDTH)) u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (ctrl),
            .cmp_key      (cmp_key),
            .new_key      (cmp_key),
            .new_payload  (new_payload),
            .left_key     (cell_key[i-1]),
            .left_payload (cell_payload[i-1]),
            .left_valid   (valid_vec[i-1]),
            .left_lt      (lt_vec[i-1]),
            .key          (cell_key[i]),
            .payload      (cell_payload[i]),
            .valid        (valid_vec[i]),
            .lt           (lt_vec[i]),
            .eq           (eq_vec[i])
         );
      end
   end

   // lt bits form a prefix, so the insertion point is the single 1-to-0 step
   assign boundary = {lt_vec, 1'b1} & ~{1'b0, lt_vec};

   always_comb begin
      position = '0;
      for (int i = 0; i <= TABLE_DEPTH; i++) begin
         if (boundary[i]) begin
            position = position | POS_W'(i);
         end
      end
   end

   // keys are unique, so at most one eq bit is set
   always_comb begin
      found_payload = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (eq_vec[i]) begin
            found_payload = found_payload | cell_payload[i];
         end
      end
   end

   assign status.hit  = |eq_vec;
   assign status.full = valid_vec[TABLE_DEPTH-1];

`ifndef SYNTHESIS
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + TABLE_DEPTH'(1)) & valid_vec) == '0)
      else $error("valid entries are not a contiguous prefix");

   a_unique_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(eq_vec))
      else $error("search key matched more than one entry");

   a_lt_within_valid: assert property (@(posedge clock) disable iff (reset)
      (lt_vec & ~valid_vec) == '0)
      else $error("less-than flag set on an empty entry");
`endif

endmodule

### rtl/sorted_key_table_top.sv
// sorted key table top level: request capture, sequencing and result register
// An item is accepted in an idle cycle. In the compare state every entry cell compares its
// key with the search key; in the apply state the cells shift up behind the insertion point
// for an insert that is neither a duplicate nor into a full table, and the result register
// is loaded. The next item is taken once the previous one has reached the result register,
// even while that result still waits; no new item is taken before the last one is through.
// A stalled result holds the following item in the apply state until it is taken.
// Entries live in a chain of TABLE_DEPTH cells; the insertion point and the found payload
// come from the registered compare flags of all cells. The table is empty after reset with
// no clearing pass.
module sorted_key_table_top #(
   parameter int TABLE_DEPTH   = skt_pkg::TABLE_DEPTH_DEFAULT,
   parameter int PAYLOAD_WIDTH = skt_pkg::PAYLOAD_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_opcode,
   input  logic [skt_pkg::KEY_WIDTH-1:0]           req_key,
   input  logic [skt_pkg::PAYLOAD_IN_WIDTH-1:0]    req_payload,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [skt_pkg::STATUS_WIDTH-1:0]        rsp_status,
   output logic [skt_pkg::PAYLOAD_OUT_WIDTH-1:0]   rsp_payload_out,
   output logic [skt_pkg::POSITION_WIDTH-1:0]      rsp_position
);

   localparam int POS_W = $clog2(TABLE_DEPTH + 1);

   skt_pkg::state_type                     state_ff, state_in;
   skt_pkg::op_type                        op_ff;
   logic [skt_pkg::KEY_WIDTH-1:0]          key_ff;
   logic [PAYLOAD_WIDTH-1:0]               payload_ff;
   skt_pkg::cell_ctrl_type                 ctrl;
   skt_pkg::chain_status_type              chain_status;
   logic [POS_W-1:0]                       position;
   logic [PAYLOAD_WIDTH-1:0]               found_payload;
   logic                                   out_free;
   logic                                   accept;
   logic                                   advance;
   skt_pkg::status_type                    status;
   logic                                   rsp_valid_ff, rsp_valid_in;
   skt_pkg::status_type                    rsp_status_ff;
   logic [skt_pkg::PAYLOAD_OUT_WIDTH-1:0]  rsp_payload_ff;
   logic [skt_pkg::POSITION_WIDTH-1:0]     rsp_position_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in   = state_ff;
      req_stall  = 1'b1;
      accept     = 1'b0;
      advance    = 1'b0;
      ctrl       = '0;
      unique case (state_ff)
         skt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
            if (req_valid) begin
               state_in = skt_pkg::ST_COMPARE;
            end
         end
         skt_pkg::ST_COMPARE: begin
            ctrl.compare_en = 1'b1;
            state_in        = skt_pkg::ST_APPLY;
         end
         skt_pkg::ST_APPLY: begin
            if (out_free) begin
               advance        = 1'b1;
               ctrl.insert_en = (op_ff == skt_pkg::OP_INSERT) && !chain_status.hit
                                && !chain_status.full;
               state_in       = skt_pkg::ST_IDLE;
            end
         end
         default: state_in = skt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= skt_pkg::op_type'(req_opcode);
         key_ff     <= req_key;
         payload_ff <= PAYLOAD_WIDTH'(req_payload);
      end
   end

   skt_chain #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_chain (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .cmp_key       (key_ff),
      .new_payload   (payload_ff),
      .status        (chain_status),
      .position      (position),
      .found_payload (found_payload)
   );

   // duplicate check ranks ahead of the capacity check
   always_comb begin
      if (op_ff == skt_pkg::OP_INSERT) begin
         if (chain_status.hit) begin
            status = skt_pkg::STATUS_DUPLICATE;
         end else if (chain_status.full) begin
            status = skt_pkg::STATUS_FULL;
         end else begin
            status = skt_pkg::STATUS_INSERTED;
         end
      end else if (chain_status.hit) begin
         status = skt_pkg::STATUS_FOUND;
      end else begin
         status = skt_pkg::STATUS_NOT_FOUND;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff   <= status;
         rsp_position_ff <= skt_pkg::POSITION_WIDTH'(position);
         if (status == skt_pkg::STATUS_FOUND) begin
            rsp_payload_ff <= skt_pkg::PAYLOAD_OUT_WIDTH'(found_payload);
         end else begin
            rsp_payload_ff <= '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_payload_out = rsp_payload_ff;
   assign rsp_position    = rsp_position_ff;

`ifndef SYNTHESIS
   a_apply_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && (state_ff == skt_pkg::ST_IDLE))
      else $error("finished item did not reach the result register");

   a_no_insert_when_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert_en |-> !chain_status.full && !chain_status.hit)
      else $error("insert shifted a full table or a duplicate key");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_status_ff)
         && $stable(rsp_position_ff) && $stable(rsp_payload_ff))
      else $error("stalled result changed before it was taken");
`endif

endmodule

### tb/sorted_key_table_top_test.sv
// testbench for the sorted key table: directed and random insert and find traffic checked against a scoreboard
`timescale 1ns / 1ps

module sorted_key_table_top_test;

   localparam int DEPTH        = skt_pkg::TABLE_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1750;
   localparam int IDLE_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 10;

   typedef struct {
      skt_pkg::status_type                    status;
      logic [skt_pkg::PAYLOAD_OUT_WIDTH-1:0]  payload_out;
      logic [skt_pkg::POSITION_WIDTH-1:0]     position;
   } lookup_result_type;

   class key_table_scoreboard;
      logic [skt_pkg::KEY_WIDTH-1:0]         table_keys [DEPTH];
      logic [skt_pkg::PAYLOAD_IN_WIDTH-1:0]  table_payloads [DEPTH];
      int                                    entry_total = 0;
      lookup_result_type                     pending_results [$];
      int                                    errors = 0;

      function void report(string msg);
         $display("%s", msg);
         errors++;
      endfunction

      // first entry whose key is not below k
      function int insertion_point(logic [skt_pkg::KEY_WIDTH-1:0] k);
         int i;
         for (i = 0; i < entry_total; i++) begin
            if (table_keys[i] >= k) return i;
         end
         return entry_total;
      endfunction

      function void note_request(skt_pkg::op_type op, logic [skt_pkg::KEY_WIDTH-1:0] k,
                                 logic [skt_pkg::PAYLOAD_IN_WIDTH-1:0] pl);
         lookup_result_type r;
         int                pos;
         bit                hit;
         int                i;
         pos = insertion_point(k);
         hit = (pos < entry_total) && (table_keys[pos] == k);
         r.payload_out = '0;
         r.position    = pos[skt_pkg::POSITION_WIDTH-1:0];
         if (op == skt_pkg::OP_INSERT) begin
            if (hit) begin
               r.status = skt_pkg::STATUS_DUPLICATE;
            end else if (entry_total >= DEPTH) begin
               r.status = skt_pkg::STATUS_FULL;
            end else begin
               for (i = entry_total; i > pos; i--) begin
                  table_keys[i]     = table_keys[i-1];
                  table_payloads[i] = table_payloads[i-1];
               end
               table_keys[pos]     = k;
               table_payloads[pos] = pl;
               entry_total++;
               r.status = skt_pkg::STATUS_INSERTED;
            end
         end else begin
            if (hit) begin
               r.status      = skt_pkg::STATUS_FOUND;
               r.payload_out = table_payloads[pos];
            end else begin
               r.status = skt_pkg::STATUS_NOT_FOUND;
            end
         end
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void check_response(logic [skt_pkg::STATUS_WIDTH-1:0] status,
                                   logic [skt_pkg::PAYLOAD_OUT_WIDTH-1:0] pl,
                                   logic [skt_pkg::POSITION_WIDTH-1:0] pos);
         lookup_result_type r;
         if (pending_results.size() == 0) begin
            report($sformatf("%0t unexpected item: expected none, actual status %0d %s %h %s %0d",
                             $time, status, "payload", pl, "position", pos));
            return;
         end
         r = pending_results.pop_front();
         if (status !== r.status)
            report($sformatf("%0t status mismatch: expected %0d actual %0d",
                             $time, r.status, status));
         if (pl !== r.payload_out)
            report($sformatf("%0t payload_out mismatch: expected %h actual %h",
                             $time, r.payload_out, pl));
         if (pos !== r.position)
            report($sformatf("%0t position mismatch: expected %0d actual %0d",
                             $time, r.position, pos));
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      function logic [skt_pkg::KEY_WIDTH-1:0] stored_key();
         if (entry_total == 0) return $urandom;
         return table_keys[$urandom_range(0, entry_total - 1)];
      endfunction
   endclass

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_stall;
   logic                                   req_opcode;
   logic [skt_pkg::KEY_WIDTH-1:0]          req_key;
   logic [skt_pkg::PAYLOAD_IN_WIDTH-1:0]   req_payload;
   logic                                   rsp_valid;
   logic                                   rsp_stall;
   logic [skt_pkg::STATUS_WIDTH-1:0]       rsp_status;
   logic [skt_pkg::PAYLOAD_OUT_WIDTH-1:0]  rsp_payload_out;
   logic [skt_pkg::POSITION_WIDTH-1:0]     rsp_position;

   key_table_scoreboard sb;
   bit sender_calm;
   bit receiver_calm;
   int rsp_wait;
   int idle_cycles;

   sorted_key_table_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_payload_out (rsp_payload_out),
      .rsp_position    (rsp_position)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // result side: stall for a drawn number of cycles after each item
   always @(negedge clock) begin
      if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait = rsp_wait - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_status, rsp_payload_out, rsp_position);
         rsp_wait = receiver_calm ? 0 : $urandom_range(0, 15);
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (!reset && rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[sorted_key_table_top] ERROR");
      $finish;
   end

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_item(skt_pkg::op_type op, logic [skt_pkg::KEY_WIDTH-1:0] k,
                            logic [skt_pkg::PAYLOAD_IN_WIDTH-1:0] pl);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_key     <= k;
      req_payload <= pl;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_request(op, k, pl);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.outstanding() > 0);
   endtask

   function automatic logic [skt_pkg::KEY_WIDTH-1:0] draw_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return sb.stored_key();
      if (r < 45) return ($urandom_range(0, 1) != 0) ? sb.stored_key() + 1 : sb.stored_key() - 1;
      if (r < 55) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFE;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   typedef struct {
      skt_pkg::op_type                       op;
      logic [skt_pkg::KEY_WIDTH-1:0]         k;
      logic [skt_pkg::PAYLOAD_IN_WIDTH-1:0]  pl;
   } table_request_type;

   table_request_type directed [$];

   initial begin
      int              n;
      int              i;
      skt_pkg::op_type op;
      sb = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = skt_pkg::OP_INSERT;
      req_key         = '0;
      req_payload     = '0;
      rsp_stall       = 1'b0;
      rsp_wait        = 0;
      sender_calm     = 1'b0;
      receiver_calm   = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, extremes, key below every entry, duplicates
      directed = '{
         '{skt_pkg::OP_FIND,   32'h0000_0000, 32'h0000_0000},
         '{skt_pkg::OP_FIND,   32'hFFFF_FFFF, 32'hFFFF_FFFF},
         '{skt_pkg::OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF},
         '{skt_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000},
         '{skt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5},
         '{skt_pkg::OP_INSERT, 32'h8000_0000, 32'h1234_5678},
         '{skt_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A},
         '{skt_pkg::OP_INSERT, 32'h8000_0001, 32'h0F0F_0F0F},
         '{skt_pkg::OP_FIND,   32'h0000_0000, 32'hFFFF_FFFF},
         '{skt_pkg::OP_FIND,   32'hFFFF_FFFF, 32'h0000_0000},
         '{skt_pkg::OP_FIND,   32'h8000_0000, 32'hFFFF_FFFF},
         '{skt_pkg::OP_FIND,   32'h1234_5678, 32'h0000_0000},
         '{skt_pkg::OP_INSERT, 32'h0000_0000, 32'hDEAD_BEEF},
         '{skt_pkg::OP_INSERT, 32'h0000_0001, 32'hF0F0_F0F0},
         '{skt_pkg::OP_FIND,   32'h0000_0001, 32'h0000_0000},
         '{skt_pkg::OP_FIND,   32'hFFFF_FFFE, 32'h0000_0000}
      };
      foreach (directed[j]) send_item(directed[j].op, directed[j].k, directed[j].pl);
      drain_results();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            sender_calm   = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
         end
         if (n == RANDOM_ITEMS / 2) drain_results();
         // fill the table quickly, then keep probing it once full
         i  = $urandom_range(0, 99);
         op = (i < ((sb.entry_total < DEPTH) ? 60 : 40)) ? skt_pkg::OP_INSERT
                                                         : skt_pkg::OP_FIND;
         send_item(op, draw_key(), $urandom);
      end

      req_valid <= 1'b0;
      while (sb.outstanding() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("[sorted_key_table_top] OK");
      end else begin
         $display("[sorted_key_table_top] ERROR");
      end
      $finish;
   end

endmodule
